### rtl/assert_macros.svh
// assertion helpers for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a given clock, disabled while the given reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check on the block clock and reset
`define ASSERT_BLOCK(label, prop, msg) \
   `ASSERT_CLK_RST(label, clock, reset, prop, msg)

`endif

### rtl/pfc_pkg.sv
package pfc_pkg;

   // square geometry
   localparam int unsigned SIDE    = 5;
   localparam int unsigned CELLS   = SIDE * SIDE;
   localparam int unsigned IDX_W   = 5;
   localparam int unsigned COORD_W = 3;
   localparam int unsigned POS_W   = 2 * COORD_W;

   localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(SIDE - 1);
   localparam logic [IDX_W-1:0]   IDX_LAST   = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0]   CELL_COUNT = IDX_W'(CELLS);

   // ascii codes
   localparam logic [7:0] ASCII_UA  = 8'h41;
   localparam logic [7:0] ASCII_UZ  = 8'h5A;
   localparam logic [7:0] ASCII_LA  = 8'h61;
   localparam logic [7:0] ASCII_LZ  = 8'h7A;
   localparam logic [7:0] CASE_GAP  = 8'h20;
   localparam logic [4:0] J_OFFSET  = 5'd9;

   typedef enum logic [1:0] {
      MODE_KEY = 2'd0,
      MODE_ENC = 2'd1,
      MODE_DEC = 2'd2,
      MODE_NOP = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      OUT_ZERO   = 2'd0,
      OUT_BAD    = 2'd1,
      OUT_CIPHER = 2'd2
   } out_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_EXEC = 3'd1,
      ST_FILL = 3'd2,
      ST_SQR  = 3'd3,
      ST_OUT  = 3'd4
   } state_type;

   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] idx;
   } letter_type;

   typedef struct packed {
      logic        latch_req;
      logic        key_commit;
      logic        fill_start;
      logic        fill_step;
      logic        pos_read;
      logic        sq_read;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     complete;
      logic     fill_last;
      logic     key_bad;
      logic     pair_bad;
   } status_type;

   // byte to square index, case folded, j merged into i
   function automatic letter_type letter_index(input logic [7:0] b);
      logic [7:0] u;
      logic [4:0] v;
      letter_type r;
      u = (b >= ASCII_LA && b <= ASCII_LZ) ? b - CASE_GAP : b;
      r.ok = (u >= ASCII_UA && u <= ASCII_UZ);
      v = 5'(u - ASCII_UA);
      if (v == J_OFFSET) begin
         r.idx = J_OFFSET - 5'd1;
      end else if (v > J_OFFSET) begin
         r.idx = v - 5'd1;
      end else begin
         r.idx = v;
      end
      return r;
   endfunction

   // square index back to uppercase ascii
   function automatic logic [6:0] index_letter(input logic [IDX_W-1:0] idx);
      logic [4:0] v;
      v = (idx < J_OFFSET) ? idx : idx + 5'd1;
      return 7'(ASCII_UA) + {2'b00, v};
   endfunction

   // one step along a row or column with wrap
   function automatic logic [COORD_W-1:0] wrap_step(input logic [COORD_W-1:0] c,
                                                   input logic dec);
      if (dec) begin
         return (c == '0) ? COORD_LAST : c - COORD_W'(1);
      end
      return (c == COORD_LAST) ? '0 : c + COORD_W'(1);
   endfunction

   // row and column to cell number
   function automatic logic [IDX_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
      return IDX_W'({r, 2'b00}) + IDX_W'(r) + IDX_W'(c);
   endfunction

endpackage

### rtl/pfc_ram.sv
module pfc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // two registered read ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### rtl/pfc_datapath.sv
module pfc_datapath import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] req_mode,
   input  logic       req_start_key,
   input  logic [7:0] req_letter_a,
   input  logic [7:0] req_letter_b,
   input  cmd_type    cmd,
   output status_type status,
   output logic [6:0] rsp_out_a,
   output logic [6:0] rsp_out_b,
   output logic       rsp_bad_letter
);

   mode_type         mode_ff;
   logic             start_ff;
   logic [7:0]       la_ff;
   logic [7:0]       lb_ff;

   logic [CELLS-1:0]   used_ff,     used_in;
   logic [IDX_W-1:0]   count_ff,    count_in;
   logic [COORD_W-1:0] row_ff,      row_in;
   logic [COORD_W-1:0] col_ff,      col_in;
   logic               complete_ff, complete_in;
   logic [IDX_W-1:0]   fill_idx_ff, fill_idx_in;

   logic [6:0] out_a_ff;
   logic [6:0] out_b_ff;
   logic       bad_ff;

   letter_type ia;
   letter_type ib;

   logic [CELLS-1:0]   used_eff;
   logic [IDX_W-1:0]   count_eff;
   logic [COORD_W-1:0] row_eff;
   logic [COORD_W-1:0] col_eff;
   logic               complete_eff;
   logic               clear;
   logic [IDX_W-1:0]   place_idx;
   logic               place_en;

   logic [POS_W-1:0] pos_a;
   logic [POS_W-1:0] pos_b;
   logic [IDX_W-1:0] sq_a;
   logic [IDX_W-1:0] sq_b;
   logic [COORD_W-1:0] r1, c1, r2, c2;
   logic [IDX_W-1:0] n1, n2;
   logic             dec;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         mode_ff  <= mode_type'(req_mode);
         start_ff <= req_start_key;
         la_ff    <= req_letter_a;
         lb_ff    <= req_letter_b;
      end
   end

   assign ia = letter_index(la_ff);
   assign ib = letter_index(lb_ff);

   // key placement and alphabet fill
   always_comb begin
      clear        = cmd.key_commit && start_ff;
      used_eff     = clear ? '0 : used_ff;
      count_eff    = clear ? '0 : count_ff;
      row_eff      = clear ? '0 : row_ff;
      col_eff      = clear ? '0 : col_ff;
      complete_eff = clear ? 1'b0 : complete_ff;

      place_idx = cmd.fill_step ? fill_idx_ff : ia.idx;
      place_en  = ((cmd.key_commit && ia.ok && !complete_eff) || cmd.fill_step)
                  && !used_eff[place_idx] && (count_eff < CELL_COUNT);

      used_in  = used_eff;
      count_in = count_eff;
      row_in   = row_eff;
      col_in   = col_eff;
      if (place_en) begin
         used_in[place_idx] = 1'b1;
         count_in = count_eff + IDX_W'(1);
         if (col_eff == COORD_LAST) begin
            col_in = '0;
            row_in = row_eff + COORD_W'(1);
         end else begin
            col_in = col_eff + COORD_W'(1);
         end
      end

      complete_in = complete_eff;
      if (cmd.fill_step && status.fill_last) begin
         complete_in = 1'b1;
      end

      fill_idx_in = fill_idx_ff;
      if (cmd.fill_start) begin
         fill_idx_in = '0;
      end else if (cmd.fill_step) begin
         fill_idx_in = fill_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         count_ff    <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         complete_ff <= 1'b0;
         fill_idx_ff <= '0;
      end else begin
         used_ff     <= used_in;
         count_ff    <= count_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         complete_ff <= complete_in;
         fill_idx_ff <= fill_idx_in;
      end
   end

   // cell of each letter, stored as row and column
   pfc_ram #(
      .WIDTH (POS_W),
      .DEPTH (CELLS)
   ) u_pos_ram (
      .clock     (clock),
      .wr_en     (place_en),
      .wr_addr   (place_idx),
      .wr_data   ({row_eff, col_eff}),
      .rd_en     (cmd.pos_read),
      .rd_addr_a (ia.idx),
      .rd_addr_b (ib.idx),
      .rd_data_a (pos_a),
      .rd_data_b (pos_b)
   );

   // substitution rules
   always_comb begin
      dec = (mode_ff == MODE_DEC);
      r1  = pos_a[POS_W-1:COORD_W];
      c1  = pos_a[COORD_W-1:0];
      r2  = pos_b[POS_W-1:COORD_W];
      c2  = pos_b[COORD_W-1:0];
      if (r1 == r2) begin
         n1 = cell_addr(r1, wrap_step(c1, dec));
         n2 = cell_addr(r2, wrap_step(c2, dec));
      end else if (c1 == c2) begin
         n1 = cell_addr(wrap_step(r1, dec), c1);
         n2 = cell_addr(wrap_step(r2, dec), c2);
      end else begin
         n1 = cell_addr(r1, c2);
         n2 = cell_addr(r2, c1);
      end
   end

   // letter held in each cell
   pfc_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CELLS)
   ) u_square_ram (
      .clock     (clock),
      .wr_en     (place_en),
      .wr_addr   (count_eff),
      .wr_data   (place_idx),
      .rd_en     (cmd.sq_read),
      .rd_addr_a (n1),
      .rd_addr_b (n2),
      .rd_data_a (sq_a),
      .rd_data_b (sq_b)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         case (cmd.out_sel)
            OUT_CIPHER: begin
               out_a_ff <= index_letter(sq_a);
               out_b_ff <= index_letter(sq_b);
               bad_ff   <= 1'b0;
            end
            OUT_BAD: begin
               out_a_ff <= '0;
               out_b_ff <= '0;
               bad_ff   <= 1'b1;
            end
            default: begin
               out_a_ff <= '0;
               out_b_ff <= '0;
               bad_ff   <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_out_a      = out_a_ff;
   assign rsp_out_b      = out_b_ff;
   assign rsp_bad_letter = bad_ff;

   assign status.mode      = mode_ff;
   assign status.complete  = complete_ff;
   assign status.fill_last = (fill_idx_ff == IDX_LAST);
   assign status.key_bad   = !ia.ok;
   assign status.pair_bad  = !ia.ok || !ib.ok;

endmodule

### rtl/pfc_ctrl.sv
module pfc_ctrl import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register can be loaded when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencing of one request
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = OUT_ZERO;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (status.mode)
               MODE_KEY: begin
                  if (out_free) begin
                     cmd.key_commit = 1'b1;
                     cmd.load_out   = 1'b1;
                     cmd.out_sel    = status.key_bad ? OUT_BAD : OUT_ZERO;
                     state_in       = ST_IDLE;
                  end
               end
               MODE_ENC, MODE_DEC: begin
                  if (!status.complete) begin
                     cmd.fill_start = 1'b1;
                     state_in       = ST_FILL;
                  end else if (status.pair_bad) begin
                     if (out_free) begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OUT_BAD;
                        state_in     = ST_IDLE;
                     end
                  end else begin
                     cmd.pos_read = 1'b1;
                     state_in     = ST_SQR;
                  end
               end
               default: begin
                  if (out_free) begin
                     cmd.load_out = 1'b1;
                     cmd.out_sel  = OUT_ZERO;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_SQR: begin
            cmd.sq_read = 1'b1;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_CIPHER;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/playfair_digraph_cipher.sv
// Playfair digraph engine. Key-letter requests (mode 0) build the 5x5 square
// in arrival order, skipping letters already placed; start_key clears the
// square first. The first pair request after the key fills the remaining
// letters alphabetically (J folded into I), then pair requests encrypt
// (mode 1) or decrypt (mode 2) two letters; mode 3 returns all zeros. Every
// request gives exactly one response. A pair of two letters passes through
// the letter-to-cell memory read and then the cell-to-letter memory read, in
// series. The first pair after a new key first runs the alphabet fill, one
// letter per cycle through the shared memory write port. A waiting response
// does not block the next request from being accepted.
`include "assert_macros.svh"

module playfair_digraph_cipher import pfc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic       req_start_key,
   input  logic [7:0] req_letter_a,
   input  logic [7:0] req_letter_b,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_out_a,
   output logic [6:0] rsp_out_b,
   output logic       rsp_bad_letter
);

   cmd_type    cmd;
   status_type status;

   logic rsp_blank;
   logic rsp_letters_ok;

   // sequencer
   pfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // square storage and substitution
   pfc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_start_key  (req_start_key),
      .req_letter_a   (req_letter_a),
      .req_letter_b   (req_letter_b),
      .cmd            (cmd),
      .status         (status),
      .rsp_out_a      (rsp_out_a),
      .rsp_out_b      (rsp_out_b),
      .rsp_bad_letter (rsp_bad_letter)
   );

   // response terms used by the checks
   assign rsp_blank      = (rsp_out_a == 7'd0) && (rsp_out_b == 7'd0);
   assign rsp_letters_ok = (rsp_out_a inside {[7'h41:7'h5A]}) && (rsp_out_a != 7'h4A)
                           && (rsp_out_b inside {[7'h41:7'h5A]}) && (rsp_out_b != 7'h4A);

   // one request in flight at a time
   `ASSERT_BLOCK(a_one_in_flight, req_valid && !req_stall |=> req_stall, "request while busy")

   // an error response carries no letters
   `ASSERT_BLOCK(a_bad_is_blank, rsp_valid && rsp_bad_letter |-> rsp_blank, "letters on error")

   // result letters are uppercase and never J
   `ASSERT_BLOCK(a_letter_range, rsp_valid && !rsp_blank |-> rsp_letters_ok, "letter out of range")

endmodule
